FILE: design/pstm_pkg.sv
// Shared types and constants for the pedal sample to MIDI value block.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pstm_pkg;

  localparam int RAW_W   = 12;
  localparam int VAL_W   = 7;
  localparam int TIME_W  = 32;
  localparam int DIV_W   = 19;  // holds (raw span) * 127
  localparam int IDX_W   = 3;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int RECIP_W = 15;
  localparam int SCL_W   = PROD_W + RECIP_W;

  localparam logic [RAW_W-1:0]  RAW_MAX      = 12'hFFF;
  localparam logic [RAW_W-1:0]  MIN_SPAN     = 12'd8;
  localparam logic [RAW_W-1:0]  FULL_SCALE   = 12'd127;
  localparam logic [VAL_W-1:0]  VAL_MAX      = 7'd127;
  localparam logic [7:0]        NOTHING_SENT = 8'hFF;
  localparam logic [TIME_W-1:0] THROTTLE_MS  = 32'd25;
  localparam logic [IDX_W-1:0]  TOP_BIT      = 3'd6;

  // floor(p / 127) == (p * 16514) >> 21 for every p up to 127 * 127
  localparam logic [RECIP_W-1:0] RECIP_127   = 15'd16514;
  localparam int                 RECIP_SHIFT = 21;

  // message kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_CC   = 2'd1;
  localparam logic [1:0] KIND_PC   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_CAL_LOW  = 3'd0;
  localparam logic [2:0] REG_CAL_HIGH = 3'd1;
  localparam logic [2:0] REG_KIND     = 3'd2;
  localparam logic [2:0] REG_PARAM_A  = 3'd3;
  localparam logic [2:0] REG_PARAM_B  = 3'd4;
  localparam logic [2:0] REG_PARAM_C  = 3'd5;
  localparam logic [2:0] REG_CHANNEL  = 3'd6;

  typedef struct packed {
    logic [RAW_W-1:0] cal_low_point;
    logic [RAW_W-1:0] cal_high_point;
    logic [1:0]       message_kind;
    logic [VAL_W-1:0] param_a;
    logic [VAL_W-1:0] param_b;
    logic [VAL_W-1:0] param_c;
    logic [7:0]       midi_channel;
  } cfg_t;

  typedef struct packed {
    logic             capture;   // input transaction taken
    logic             prep;      // clamp and load the division
    logic             div_step;  // one restoring step of the divider
    logic             mul;       // range multiply
    logic             scale;     // divide the range product by 127
    logic             finish;    // decide and write the output register
    logic [IDX_W-1:0] bit_idx;   // quotient bit of this step
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: design/pstm_cfg_regs.sv
// Configuration registers behind an APB-style port.
// Depends on pstm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pstm_cfg_regs import pstm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output cfg_t             cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cal_low_point  <= '0;
      cfg.cal_high_point <= RAW_MAX;
      cfg.message_kind   <= KIND_NONE;
      cfg.param_a        <= '0;
      cfg.param_b        <= '0;
      cfg.param_c        <= VAL_MAX;
      cfg.midi_channel   <= 8'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CAL_LOW:  cfg.cal_low_point  <= pwdata[RAW_W-1:0];
        REG_CAL_HIGH: cfg.cal_high_point <= pwdata[RAW_W-1:0];
        REG_KIND:     cfg.message_kind   <= pwdata[1:0];
        REG_PARAM_A:  cfg.param_a        <= pwdata[VAL_W-1:0];
        REG_PARAM_B:  cfg.param_b        <= pwdata[VAL_W-1:0];
        REG_PARAM_C:  cfg.param_c        <= pwdata[VAL_W-1:0];
        REG_CHANNEL:  cfg.midi_channel   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CAL_LOW:  prdata = {20'd0, cfg.cal_low_point};
      REG_CAL_HIGH: prdata = {20'd0, cfg.cal_high_point};
      REG_KIND:     prdata = {30'd0, cfg.message_kind};
      REG_PARAM_A:  prdata = {25'd0, cfg.param_a};
      REG_PARAM_B:  prdata = {25'd0, cfg.param_b};
      REG_PARAM_C:  prdata = {25'd0, cfg.param_c};
      REG_CHANNEL:  prdata = {24'd0, cfg.midi_channel};
      default:      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/pstm_divider.sv
// Restoring divider for the calibration scaling, one quotient bit per step,
// seven-bit quotient. The caller guarantees num < 128 * den. Depends on pstm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pstm_divider import pstm_pkg::*; (
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [RAW_W-1:0] den,
  input  wire logic             step,
  input  wire logic [IDX_W-1:0] idx,
  output logic      [VAL_W-1:0] quot
);

  logic [DIV_W-1:0] rem;
  logic [RAW_W-1:0] den_r;
  logic [DIV_W-1:0] trial;

  assign trial = DIV_W'(den_r) << idx;

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= num;
      den_r <= den;
      quot  <= '0;
    end else if (step && rem >= trial) begin
      rem       <= rem - trial;
      quot[idx] <= 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: design/pstm_datapath.sv
// Datapath: held sample, calibration scaling, range mapping, throttle and
// the output register. Driven by pstm_ctrl; uses pstm_divider and pstm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pstm_datapath import pstm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire cfg_t        cfg,
  input  wire logic [15:0] in_sample,
  input  wire logic        in_read_ok,
  input  wire logic [31:0] in_time,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,
  output logic [1:0]       m_tuser
);

  logic [RAW_W-1:0]  held;
  logic [TIME_W-1:0] t_cur;
  logic [RAW_W-1:0]  lo_s, hi_s;
  logic              narrow;
  logic [VAL_W-1:0]  v1_r;
  logic              asc_r;
  logic [VAL_W-1:0]  last_val;   // last taken value
  logic              none_sent;  // nothing taken since reset
  logic [TIME_W-1:0] last_time;

  // prep stage
  logic [RAW_W-1:0] span, r_clamp, x;
  logic [DIV_W-1:0] n_first;
  assign span    = hi_s - lo_s;
  assign r_clamp = (held < lo_s) ? lo_s : ((held > hi_s) ? hi_s : held);
  assign x       = r_clamp - lo_s;
  assign n_first = {x, 7'd0} - DIV_W'(x);

  // range mapping
  logic [VAL_W-1:0]  v1, v2, diff;
  logic              asc;
  logic [PROD_W-1:0] prod, prod_r;
  logic [SCL_W-1:0]  prod_scaled;
  logic [VAL_W-1:0]  scaled_val;
  logic [VAL_W-1:0]  quot;

  always_comb begin
    case (cfg.message_kind)
      KIND_CC: begin
        v1 = cfg.param_b;
        v2 = cfg.param_c;
      end
      KIND_PC: begin
        v1 = cfg.param_a;
        v2 = cfg.param_b;
      end
      default: begin
        v1 = '0;
        v2 = VAL_MAX;
      end
    endcase
  end
  assign asc  = v2 >= v1;
  assign diff = asc ? (v2 - v1) : (v1 - v2);
  assign prod = PROD_W'(quot) * PROD_W'(diff);

  // divide by 127 through a reciprocal multiply
  assign prod_scaled = SCL_W'(prod_r) * SCL_W'(RECIP_127);

  pstm_divider u_div (
    .clk  (clk),
    .load (cmd.prep),
    .num  (n_first),
    .den  (span),
    .step (cmd.div_step),
    .idx  (cmd.bit_idx),
    .quot (quot)
  );

  // final decision
  logic [VAL_W-1:0]  mapped;
  logic [TIME_W-1:0] elapsed;
  logic              take, send;
  logic [4:0]        chan;

  assign mapped  = narrow ? '0 : (asc_r ? (v1_r + scaled_val) : (v1_r - scaled_val));
  assign elapsed = t_cur - last_time;
  assign take    = (none_sent || mapped != last_val) && (elapsed >= THROTTLE_MS);
  assign send    = take && (cfg.message_kind == KIND_CC || cfg.message_kind == KIND_PC);
  assign chan    = (cfg.midi_channel == 8'd0) ? 5'd1 :
                   ((cfg.midi_channel > 8'd16) ? 5'd16 : cfg.midi_channel[4:0]);

  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t_cur <= in_time;
      lo_s  <= (cfg.cal_high_point < cfg.cal_low_point) ? cfg.cal_high_point
                                                         : cfg.cal_low_point;
      hi_s  <= (cfg.cal_high_point < cfg.cal_low_point) ? cfg.cal_low_point
                                                         : cfg.cal_high_point;
    end
    if (cmd.prep) begin
      narrow <= span < MIN_SPAN;
    end
    if (cmd.mul) begin
      prod_r <= prod;
      v1_r   <= v1;
      asc_r  <= asc;
    end
    if (cmd.scale) begin
      scaled_val <= prod_scaled[RECIP_SHIFT +: VAL_W];
    end
    if (cmd.finish) begin
      m_tuser <= {send && cfg.message_kind == KIND_PC, send};
      m_tdata <= {1'b0, held,
                  send ? mapped : 7'd0,
                  (send && cfg.message_kind == KIND_CC) ? cfg.param_a : 7'd0,
                  send ? chan : 5'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      last_val  <= '0;
      none_sent <= 1'b1;
      last_time <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.capture && in_read_ok) begin
        held <= (in_sample[15:12] != 4'd0) ? RAW_MAX : in_sample[RAW_W-1:0];
      end
      if (cmd.finish && take) begin
        last_val  <= mapped;
        none_sent <= 1'b0;
        last_time <= t_cur;
      end
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/pstm_ctrl.sv
// Controller state machine: sequences capture, scaling division, range
// multiply, reciprocal scaling and the final decision. Depends on pstm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pstm_ctrl import pstm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    s_tvalid,
  output logic         s_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_DIV1  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0]       state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.bit_idx  = cnt;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = TOP_BIT;
        state_next = ST_DIV1;
      end
      ST_DIV1: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 3'd1;
        if (cnt == '0) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold here while the previous result is still unread
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/pedal_sample_to_midi_value.sv
// Pedal sample to MIDI value: top level.
// Instantiates pstm_cfg_regs, pstm_ctrl and pstm_datapath; depends on pstm_pkg.
//
// Input stream (s_*): one ADC sample per transaction with its read-ok flag in
// s_tuser and the millisecond timestamp in s_tdata. Output stream (m_*): one
// result per input, carrying the send flag and message kind in m_tuser and
// channel, controller, value and the held raw sample in m_tdata.
// Configuration registers sit on the APB-style port at byte address 4*i and
// are to be written only while the block is idle; the block does not enforce it.
// From input transaction to output valid, the controller clamps and loads the
// divider, runs seven divider steps for the calibration scaling, then the range
// multiply, the multiply by the reciprocal of 127 and the write of the output
// register. One item is processed at a time; the next input is taken the cycle
// after the current item has been written to the output register.
// A stalled receiver holds the output register; a finished item waits in the
// controller until the register frees, and no input is taken meanwhile.
// Reset clears the held sample, marks no value as sent and restores the
// register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module pedal_sample_to_midi_value import pstm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [15:0] sample, [47:16] time_ms
  input  wire logic        s_tuser,   // [0] read_ok
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [4:0] channel_out, [11:5] controller_out,
                                      // [18:12] value_out, [30:19] held_raw
  output logic      [1:0]  m_tuser,   // [0] send_valid, [1] send_kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;

  pstm_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pstm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pstm_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg        (cfg),
    .in_sample  (s_tdata[15:0]),
    .in_read_ok (s_tuser),
    .in_time    (s_tdata[47:16]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
`default_nettype wire
